@@ rtl/core/xmlr_pkg.sv @@
// ----------------------------------------------------------------------------
// xmlr_pkg
// Shared types and constants of the x-major line rasterizer: front state
// codes, register indexes and line queue status.
// ----------------------------------------------------------------------------
package xmlr_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COLOR_BITS  = 8;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_X = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_Y = 1'b1;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/core/x_major_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// x_major_line_rasterizer_core
// Flow: a command is taken in FRONT_IDLE, the bit-serial slope divider runs
// in FRONT_DIVIDE, the line word is pushed into the queue in FRONT_PUSH, and
// the first dot is registered in the output register when the word is popped.
// Throughput: one dot per cycle from the stepper while rsp_stall does not
// hold the output register; a new command is taken only once the line word
// of the last one has been pushed.
// Reset: synchronous; clears control state, clip limits become all ones.
// ----------------------------------------------------------------------------
module x_major_line_rasterizer_core import xmlr_pkg::*; #(
   parameter int COORD_BITS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COORD_BITS-1:0]   req_x_start,
   input  logic [COORD_BITS-1:0]   req_y_start,
   input  logic [COORD_BITS-1:0]   req_x_end,
   input  logic [COORD_BITS-1:0]   req_y_end,
   input  logic [COLOR_BITS-1:0]   req_color,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COORD_BITS-1:0]   rsp_pixel_x,
   output logic [COORD_BITS-1:0]   rsp_pixel_y,
   output logic [COLOR_BITS-1:0]   rsp_write_color,
   output logic                    rsp_write_enable,
   output logic                    rsp_last_dot
);

   localparam int DESC_BITS = 6 * COORD_BITS + 1 + COLOR_BITS;

   logic [COORD_BITS-1:0] max_x_ff, max_y_ff;
   queue_status_type      queue_status;
   logic                  push, pop;
   logic [DESC_BITS-1:0]  push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= '1;
         max_y_ff <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_X: max_x_ff <= csr_write_data;
            CSR_MAX_Y: max_y_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   xmlr_front #(
      .COORD_BITS (COORD_BITS),
      .DESC_BITS  (DESC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_start  (req_x_start),
      .req_y_start  (req_y_start),
      .req_x_end    (req_x_end),
      .req_y_end    (req_y_end),
      .req_color    (req_color),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   xmlr_queue #(
      .WIDTH (DESC_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   xmlr_back #(
      .COORD_BITS (COORD_BITS),
      .DESC_BITS  (DESC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .pop_data         (pop_data),
      .pop              (pop),
      .max_x            (max_x_ff),
      .max_y            (max_y_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_write_color  (rsp_write_color),
      .rsp_write_enable (rsp_write_enable),
      .rsp_last_dot     (rsp_last_dot)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("line queue reports full and empty at once");

   assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("line word pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("line word popped from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("start dot missing after line word pop");
`endif

endmodule

@@ rtl/core/xmlr_front.sv @@
// ----------------------------------------------------------------------------
// xmlr_front
// Accepts line commands, finds the stepping direction and the floor slope
// with a bit-serial divider, and pushes one line word into the queue.
// ----------------------------------------------------------------------------
module xmlr_front import xmlr_pkg::*; #(
   parameter int COORD_BITS = 6,
   parameter int DESC_BITS  = 6 * COORD_BITS + 1 + COLOR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  logic [COLOR_BITS-1:0] req_color,
   input  queue_status_type      queue_status,
   output logic                  push,
   output logic [DESC_BITS-1:0]  push_data
);

   localparam int CB       = COORD_BITS;
   localparam int CNT_BITS = $clog2(CB);

   typedef struct packed {
      logic [COLOR_BITS-1:0] color;
      logic [CB-1:0]         n;
      logic [CB-1:0]         rem;
      logic [CB-1:0]         quot;
      logic                  dir;
      logic [CB-1:0]         x1;
      logic [CB-1:0]         y0;
      logic [CB-1:0]         x0;
   } desc_type;

   front_state_type state_ff, state_in;

   logic [CB-1:0]         x0_ff, y0_ff, x1_ff, n_ff;
   logic [CB-1:0]         dividend_ff, rem_ff, quot_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic                  dir_ff, neg_ff;
   logic [COLOR_BITS-1:0] color_ff;

   logic          accept;
   logic [CB:0]   dx, dy;
   logic [CB-1:0] n_new, a_new;
   logic [CB:0]   trial;
   logic          qbit;
   logic [CB-1:0] rem_step;
   logic [CB-1:0] quot_fin, rem_fin;
   desc_type      desc;

   always_comb begin
      dx    = {1'b0, req_x_end} - {1'b0, req_x_start};
      dy    = {1'b0, req_y_end} - {1'b0, req_y_start};
      n_new = dx[CB] ? CB'(-dx) : dx[CB-1:0];
      a_new = dy[CB] ? CB'(-dy) : dy[CB-1:0];
      trial = {rem_ff, dividend_ff[CB-1]};
      qbit  = (trial >= {1'b0, n_ff});
      rem_step = qbit ? CB'(trial - {1'b0, n_ff}) : trial[CB-1:0];
      if (neg_ff && (rem_ff != '0)) begin
         quot_fin = ~quot_ff;
         rem_fin  = n_ff - rem_ff;
      end else begin
         quot_fin = neg_ff ? CB'(-quot_ff) : quot_ff;
         rem_fin  = rem_ff;
      end
      desc.color = color_ff;
      desc.n     = n_ff;
      desc.rem   = rem_fin;
      desc.quot  = quot_fin;
      desc.dir   = dir_ff;
      desc.x1    = x1_ff;
      desc.y0    = y0_ff;
      desc.x0    = x0_ff;
      push_data  = desc;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_valid) begin
               state_in = (n_new == '0) ? FRONT_PUSH : FRONT_DIVIDE;
            end
         end
         FRONT_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (!queue_status.full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      push      = 1'b0;
      unique case (state_ff)
         FRONT_IDLE:   req_stall = 1'b0;
         FRONT_DIVIDE: req_stall = 1'b1;
         FRONT_PUSH:   push = !queue_status.full;
         default:      req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff       <= req_x_start;
         y0_ff       <= req_y_start;
         x1_ff       <= req_x_end;
         color_ff    <= req_color;
         dir_ff      <= dx[CB];
         neg_ff      <= dy[CB];
         n_ff        <= n_new;
         dividend_ff <= a_new;
         rem_ff      <= '0;
         quot_ff     <= '0;
         count_ff    <= CNT_BITS'(CB - 1);
      end else if (state_ff == FRONT_DIVIDE) begin
         rem_ff      <= rem_step;
         quot_ff     <= {quot_ff[CB-2:0], qbit};
         dividend_ff <= {dividend_ff[CB-2:0], 1'b0};
         count_ff    <= count_ff - 1'b1;
      end
   end

endmodule

@@ rtl/core/xmlr_queue.sv @@
// ----------------------------------------------------------------------------
// xmlr_queue
// Short queue of line words between the front and the dot stepper.
// ----------------------------------------------------------------------------
module xmlr_queue import xmlr_pkg::*; #(
   parameter int WIDTH = 45
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]  count_ff;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
      logic [QPTR_BITS-1:0] r;
      if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/xmlr_back.sv @@
// ----------------------------------------------------------------------------
// xmlr_back
// Dot stepper: takes queue line words and emits one dot per cycle into a
// registered output stage not held by rsp_stall, clipping against the limits.
// ----------------------------------------------------------------------------
module xmlr_back import xmlr_pkg::*; #(
   parameter int COORD_BITS = 6,
   parameter int DESC_BITS  = 6 * COORD_BITS + 1 + COLOR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      queue_status,
   input  logic [DESC_BITS-1:0]  pop_data,
   output logic                  pop,
   input  logic [COORD_BITS-1:0] max_x,
   input  logic [COORD_BITS-1:0] max_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_write_color,
   output logic                  rsp_write_enable,
   output logic                  rsp_last_dot
);

   localparam int CB = COORD_BITS;

   typedef struct packed {
      logic [COLOR_BITS-1:0] color;
      logic [CB-1:0]         n;
      logic [CB-1:0]         rem;
      logic [CB-1:0]         quot;
      logic                  dir;
      logic [CB-1:0]         x1;
      logic [CB-1:0]         y0;
      logic [CB-1:0]         x0;
   } desc_type;

   desc_type desc;

   logic                  active_ff;
   logic [CB-1:0]         cur_x_ff, cur_y_ff, target_ff, quot_ff, rem_ff, n_ff, acc_ff;
   logic                  dir_ff;
   logic [COLOR_BITS-1:0] color_ff;

   logic                  out_valid_ff;
   logic [CB-1:0]         out_x_ff, out_y_ff;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic                  out_en_ff, out_last_ff;

   logic                  can_emit, step;
   logic [CB:0]           sum;
   logic                  carry;
   logic [CB-1:0]         x_in, y_in, acc_in;
   logic [CB-1:0]         dot_x, dot_y;
   logic [COLOR_BITS-1:0] dot_color;
   logic                  dot_last;

   always_comb begin
      desc     = desc_type'(pop_data);
      can_emit = !out_valid_ff || !rsp_stall;
      pop      = !active_ff && !queue_status.empty && can_emit;
      step     = active_ff && can_emit;
      sum      = {1'b0, acc_ff} + {1'b0, rem_ff};
      carry    = (sum >= {1'b0, n_ff});
      acc_in   = carry ? CB'(sum - {1'b0, n_ff}) : sum[CB-1:0];
      x_in     = dir_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      y_in     = cur_y_ff + quot_ff + {{(CB-1){1'b0}}, carry};
      if (pop) begin
         dot_x     = desc.x0;
         dot_y     = desc.y0;
         dot_color = desc.color;
         dot_last  = (desc.x0 == desc.x1);
      end else begin
         dot_x     = x_in;
         dot_y     = y_in;
         dot_color = color_ff;
         dot_last  = (x_in == target_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            active_ff <= (desc.x0 != desc.x1);
         end else if (step && (x_in == target_ff)) begin
            active_ff <= 1'b0;
         end
         if (pop || step) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_x_ff  <= desc.x0;
         cur_y_ff  <= desc.y0;
         target_ff <= desc.x1;
         dir_ff    <= desc.dir;
         quot_ff   <= desc.quot;
         rem_ff    <= desc.rem;
         n_ff      <= desc.n;
         acc_ff    <= '0;
         color_ff  <= desc.color;
      end else if (step) begin
         cur_x_ff <= x_in;
         cur_y_ff <= y_in;
         acc_ff   <= acc_in;
      end
      if (pop || step) begin
         out_x_ff     <= dot_x;
         out_y_ff     <= dot_y;
         out_color_ff <= dot_color;
         out_en_ff    <= (dot_x <= max_x) && (dot_y <= max_y);
         out_last_ff  <= dot_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_write_color  = out_color_ff;
   assign rsp_write_enable = out_en_ff;
   assign rsp_last_dot     = out_last_ff;

endmodule
